>>> rtl/iar_pkg.sv
package iar_pkg;

	localparam int SAMPLE_DEPTH   = 4096;
	localparam int TIME_FRAC_BITS = 16;

	localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
	localparam int IDX_W  = 12;
	localparam int SAMP_W = 16;
	localparam int TIME_W = 28;

	// accumulator and numerator widths follow from depth and time resolution
	localparam int MID_W = SAMP_W + ADDR_W;
	localparam int M2_W  = MID_W + 2;
	localparam int P_W   = M2_W + TIME_FRAC_BITS + 2;
	localparam int NUM_W = P_W + TIME_FRAC_BITS + 1;
	localparam int QUO_W = SAMP_W;

	localparam logic [TIME_W-1:0] TIME_LIMIT =
		TIME_W'(SAMPLE_DEPTH - 1) << TIME_FRAC_BITS;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic                     mode;
		logic [IDX_W-1:0]         sample_index;
		logic signed [SAMP_W-1:0] sample_value;
		logic [TIME_W-1:0]        start_time;
		logic [TIME_W-1:0]        stop_time;
	} item_t;

	typedef struct packed {
		logic signed [SAMP_W-1:0] mean_value;
		logic                     bad_interval;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_MUL1,
		ST_MUL2,
		ST_SUM1,
		ST_SUM2,
		ST_DIV_GO,
		ST_DIV_WAIT
	} state_t;

	typedef enum logic [2:0] {
		PH_S0,
		PH_S1,
		PH_T0,
		PH_T1,
		PH_MID
	} rd_phase_t;

endpackage

>>> rtl/iar_div.sv
module iar_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [iar_pkg::NUM_W-1:0] num,
	input  logic [iar_pkg::NUM_W-1:0] den,
	output logic                      done,
	output logic [iar_pkg::QUO_W-1:0] quo
);

	localparam int CNT_W = $clog2(iar_pkg::QUO_W);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [iar_pkg::NUM_W-1:0] rem_q;
	logic [iar_pkg::NUM_W-1:0] dsh_q;
	logic [iar_pkg::QUO_W-1:0] quo_q;
	logic                      ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(iar_pkg::QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// restoring divide, one quotient bit a cycle, msb first
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= num;
			dsh_q <= den << (iar_pkg::QUO_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[iar_pkg::QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> rtl/interval_average_resampler.sv
// Channel  Direction  Handshake           Payload
// item     in         start & !busy       iar_pkg::item_t (write or query)
// result   out        done, one cycle     iar_pkg::result_t (query only)
//
// Writes leave busy low; a rejected or zero-length query strobes done in the cycle
// after acceptance. Other queries strobe done after the sequencer steps through the
// memory reads, one memory read a cycle, then up to four multiply/add steps, then
// the divider.
// Reset clears control only; the sample memory holds garbage until written.
// The receiver cannot stall: done pulses once and the result is lost if not taken.
module interval_average_resampler (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  iar_pkg::item_t    item,
	output logic              done,
	output iar_pkg::result_t  result
);

	localparam int TFB = iar_pkg::TIME_FRAC_BITS;
	localparam int AW  = iar_pkg::ADDR_W;
	localparam int SW  = iar_pkg::SAMP_W;
	localparam logic [TFB:0] D_VAL = (TFB+1)'(1) << TFB;

	iar_pkg::state_t    state_q, state_d;
	iar_pkg::rd_phase_t phase_q, phase_d, tag_s1;
	logic [AW-1:0]      kptr_q, kptr_d;
	logic               vld_s1;

	logic               accept, is_query, rev, past, zero_len;
	logic               rd_en, mem_we, div_go, div_done;
	logic [AW-1:0]      rd_addr;

	logic signed [SW-1:0] mem [iar_pkg::SAMPLE_DEPTH];
	logic signed [SW-1:0] rdata_s1;

	// query operands
	logic [AW-1:0]                 i0_q, i1_q;
	logic [TFB-1:0]                f0_q, f1_q;
	logic [iar_pkg::TIME_W-1:0]    len_q;
	logic                          same_q, adj_q;
	logic signed [SW-1:0]          s0_q, s1_q, t0_q, t1_q;
	logic signed [iar_pkg::MID_W-1:0] mid_q;

	// arithmetic pipeline
	logic signed [SW:0]            ds, dt, ss;
	logic [TFB:0]                  dmf0, fsum;
	logic signed [SW-1:0]          t1_eff;
	logic [2*TFB:0]                pa_q;
	logic [2*TFB-1:0]              pb_q;
	logic signed [SW+TFB+2:0]      pc_q, prod_same;
	logic signed [2*TFB+SW+2:0]    qa_q, qb_q;
	logic signed [SW+TFB+1:0]      pd_q;
	logic signed [iar_pkg::M2_W-1:0] m2_q;
	logic signed [iar_pkg::P_W-1:0]  pp_q;
	logic signed [iar_pkg::NUM_W-1:0] num_q;
	logic [iar_pkg::NUM_W-1:0]     den_q, div_num;
	logic                          neg_q;
	logic [iar_pkg::QUO_W-1:0]     quo;

	logic               done_q;
	iar_pkg::result_t   result_q;

	assign busy     = state_q != iar_pkg::ST_IDLE;
	assign accept   = start && !busy;
	assign is_query = item.mode == iar_pkg::MODE_QUERY;
	assign rev      = item.stop_time < item.start_time;
	assign past     = item.stop_time > iar_pkg::TIME_LIMIT;
	assign zero_len = item.stop_time == item.start_time;
	assign mem_we   = accept && !is_query &&
		(32'(item.sample_index) < iar_pkg::SAMPLE_DEPTH);

	// sequencer: next state, read addresses, divider launch
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		kptr_d  = kptr_q;
		rd_en   = 1'b0;
		rd_addr = kptr_q;
		div_go  = 1'b0;
		unique case (state_q)
			iar_pkg::ST_IDLE: begin
				if (accept && is_query && !rev && !past && !zero_len) begin
					state_d = iar_pkg::ST_READ;
					phase_d = iar_pkg::PH_S0;
				end
			end
			iar_pkg::ST_READ: begin
				rd_en = 1'b1;
				unique case (phase_q)
					iar_pkg::PH_S0: begin
						rd_addr = i0_q;
						phase_d = iar_pkg::PH_S1;
					end
					iar_pkg::PH_S1: begin
						rd_addr = i0_q + 1'b1;
						if (same_q) state_d = iar_pkg::ST_DRAIN;
						else phase_d = iar_pkg::PH_T0;
					end
					iar_pkg::PH_T0: begin
						rd_addr = i1_q;
						phase_d = iar_pkg::PH_T1;
					end
					iar_pkg::PH_T1: begin
						// beyond the last sample only when f1 is zero: ignored then
						rd_addr = i1_q + 1'b1;
						// skip the middle walk when no sample lies strictly between i0 + 1 and i1
						if (adj_q || i1_q == i0_q + AW'(2)) begin
							state_d = iar_pkg::ST_DRAIN;
						end else begin
							phase_d = iar_pkg::PH_MID;
							kptr_d  = i0_q + AW'(2);
						end
					end
					iar_pkg::PH_MID: begin
						rd_addr = kptr_q;
						kptr_d  = kptr_q + 1'b1;
						if (kptr_q == i1_q - 1'b1) state_d = iar_pkg::ST_DRAIN;
					end
					default: state_d = iar_pkg::ST_DRAIN;
				endcase
			end
			iar_pkg::ST_DRAIN:  state_d = iar_pkg::ST_MUL1;
			iar_pkg::ST_MUL1:   state_d = same_q ? iar_pkg::ST_DIV_GO : iar_pkg::ST_MUL2;
			iar_pkg::ST_MUL2:   state_d = iar_pkg::ST_SUM1;
			iar_pkg::ST_SUM1:   state_d = iar_pkg::ST_SUM2;
			iar_pkg::ST_SUM2:   state_d = iar_pkg::ST_DIV_GO;
			iar_pkg::ST_DIV_GO: begin
				div_go  = 1'b1;
				state_d = iar_pkg::ST_DIV_WAIT;
			end
			iar_pkg::ST_DIV_WAIT: begin
				if (div_done) state_d = iar_pkg::ST_IDLE;
			end
			default: state_d = iar_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iar_pkg::ST_IDLE;
			phase_q <= iar_pkg::PH_S0;
			kptr_q  <= '0;
			vld_s1  <= 1'b0;
			tag_s1  <= iar_pkg::PH_S0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			kptr_q  <= kptr_d;
			vld_s1  <= rd_en;
			tag_s1  <= phase_q;
		end
	end

	// sample memory: writes only while idle, reads only while walking
	always_ff @(posedge clk) begin
		if (mem_we) mem[item.sample_index[AW-1:0]] <= item.sample_value;
		if (rd_en) rdata_s1 <= mem[rd_addr];
	end

	assign ds     = {s1_q[SW-1], s1_q} - {s0_q[SW-1], s0_q};
	assign ss     = {s1_q[SW-1], s1_q} + {s0_q[SW-1], s0_q};
	assign t1_eff = (f1_q != '0) ? t1_q : t0_q;
	assign dt     = {t1_eff[SW-1], t1_eff} - {t0_q[SW-1], t0_q};
	assign dmf0   = D_VAL - {1'b0, f0_q};
	assign fsum   = {1'b0, f0_q} + {1'b0, f1_q};
	assign prod_same = ds * $signed({1'b0, fsum});

	always_ff @(posedge clk) begin
		if (accept) begin
			i0_q   <= item.start_time[TFB +: AW];
			i1_q   <= item.stop_time[TFB +: AW];
			f0_q   <= item.start_time[TFB-1:0];
			f1_q   <= item.stop_time[TFB-1:0];
			len_q  <= item.stop_time - item.start_time;
			same_q <= item.start_time[TFB +: AW] == item.stop_time[TFB +: AW];
			adj_q  <= item.start_time[TFB +: AW] + 1'b1 == item.stop_time[TFB +: AW];
			mid_q  <= '0;
		end
		// capture read data, registered in rdata_s1, in the cycle after its address
		if (vld_s1) begin
			unique case (tag_s1)
				iar_pkg::PH_S0:  s0_q  <= rdata_s1;
				iar_pkg::PH_S1:  s1_q  <= rdata_s1;
				iar_pkg::PH_T0:  t0_q  <= rdata_s1;
				iar_pkg::PH_T1:  t1_q  <= rdata_s1;
				iar_pkg::PH_MID: mid_q <= mid_q + iar_pkg::MID_W'(rdata_s1);
				default: ;
			endcase
		end
		unique case (state_q)
			iar_pkg::ST_MUL1: begin
				if (same_q) begin
					// mean of the two end values, scaled by 2D
					num_q <= (iar_pkg::NUM_W'(s0_q) << (TFB + 1)) +
						iar_pkg::NUM_W'(prod_same);
					den_q <= iar_pkg::NUM_W'(1) << (TFB + 1);
				end else begin
					pa_q <= f0_q * dmf0;
					pb_q <= f1_q * f1_q;
					pc_q <= $signed({1'b0, dmf0}) * ss;
				end
			end
			iar_pkg::ST_MUL2: begin
				qa_q <= $signed({1'b0, pa_q}) * ds;
				qb_q <= $signed({2'b0, pb_q}) * dt;
				pd_q <= $signed({1'b0, f1_q}) * t0_q;
				m2_q <= adj_q ? '0 : iar_pkg::M2_W'(s1_q) + iar_pkg::M2_W'(t0_q) +
					(iar_pkg::M2_W'(mid_q) <<< 1);
			end
			iar_pkg::ST_SUM1: begin
				pp_q <= (iar_pkg::P_W'(m2_q) <<< TFB) + iar_pkg::P_W'(pc_q) +
					(iar_pkg::P_W'(pd_q) <<< 1);
			end
			iar_pkg::ST_SUM2: begin
				// whole area scaled by 2*D*D, exact
				num_q <= (iar_pkg::NUM_W'(pp_q) <<< TFB) + iar_pkg::NUM_W'(qa_q) +
					iar_pkg::NUM_W'(qb_q);
				den_q <= iar_pkg::NUM_W'(len_q) << (TFB + 1);
			end
			iar_pkg::ST_DIV_GO: neg_q <= num_q[iar_pkg::NUM_W-1];
			default: ;
		endcase
	end

	// divide magnitudes so the quotient truncates toward zero
	assign div_num = num_q[iar_pkg::NUM_W-1] ? iar_pkg::NUM_W'(-num_q)
		: iar_pkg::NUM_W'(num_q);

	iar_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (den_q),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && is_query && (rev || past || zero_len)) ||
				(state_q == iar_pkg::ST_DIV_WAIT && div_done);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			result_q.mean_value   <= '0;
			result_q.bad_interval <= rev || past;
		end else if (state_q == iar_pkg::ST_DIV_WAIT && div_done) begin
			result_q.mean_value   <= neg_q ? $signed(~quo + 1'b1) : $signed(quo);
			result_q.bad_interval <= 1'b0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.bad_interval) |-> (result.mean_value == '0))
		else $error("flagged interval with nonzero mean");

	a_rev_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.mode == iar_pkg::MODE_QUERY &&
		item.stop_time < item.start_time) |=> (done && result.bad_interval))
		else $error("reversed interval not flagged");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.mode == iar_pkg::MODE_WRITE) |=> (!done && !busy))
		else $error("write item produced a result or stalled");
`endif

endmodule
